>>> design/rhfd_pkg.sv
// ---------------------------------------------------------------------------
// rhfd_pkg
// Shared widths, constants and types for the relative humidity pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package rhfd_pkg;

  // Magnus term divider: |1767*x|*2^32 + den/2 over 100*(x+24350)
  localparam int MAG_W     = 58;
  localparam int MAG_DEN_W = 23;
  localparam int MAG_Q_W   = 43;

  // split of d + 18*ln2 into k and r
  localparam int LN2_DEN_W = 32;
  localparam int LN2_Q_W   = 5;
  localparam int U_W       = LN2_DEN_W - 1 + LN2_Q_W;

  // Taylor series for exp(r)
  localparam int TERMS  = 16;
  localparam int R_W    = 32;
  localparam int TERM_W = 33;
  localparam int SUM_W  = 34;

  localparam logic [R_W-1:0]    LN2_Q32 = 32'd2977044472;
  localparam logic [TERM_W-1:0] ONE_Q32 = 33'h1_0000_0000;

  localparam logic signed [15:0] MISSING_FLOOR = -16'sd24000;
  localparam int                 MAGNUS_A      = 1767;
  localparam logic signed [16:0] DEN_BIAS      = 17'sd24350;
  localparam int                 DEN_SCALE     = 100;
  localparam int                 HUM_SCALE     = 10000;
  localparam logic [15:0]        HUM_MAX       = 16'hFFFF;

  // d limits and the bias that makes d + 18*ln2 positive
  localparam logic signed [44:0] D_HI   = 45'sd8589934592;
  localparam logic signed [44:0] D_LO   = -45'sd51539607552;
  localparam logic signed [44:0] K_BIAS = 45'sd53586800496;

  typedef struct packed {
    logic               missing;
    logic               last;
    logic               big;
    logic               small_d;
    logic [LN2_Q_W-1:0] shift;
  } rhfd_side_t;

endpackage

`default_nettype wire

>>> design/rhfd_div_cell.sv
// ---------------------------------------------------------------------------
// rhfd_div_cell
// One registered restoring-division step: develops one quotient bit.
// ---------------------------------------------------------------------------
`default_nettype none

module rhfd_div_cell #(
  parameter int DEN_W  = 23,
  parameter int Q_W    = 43,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              prev_valid,
  input  logic [DEN_W-1:0]  prev_rem,
  input  logic [Q_W-1:0]    prev_low,
  input  logic [DEN_W-1:0]  prev_den,
  input  logic [SIDE_W-1:0] prev_side,
  output logic              valid,
  output logic [DEN_W-1:0]  rem,
  output logic [Q_W-1:0]    low,
  output logic [DEN_W-1:0]  den,
  output logic [SIDE_W-1:0] side
);

  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             qbit;

  // low holds the unused dividend bits on top, quotient bits below
  assign trial = {prev_rem, prev_low[Q_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, prev_den};
  assign qbit  = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low  <= {prev_low[Q_W-2:0], qbit};
      den  <= prev_den;
      side <= prev_side;
    end
  end

endmodule

`default_nettype wire

>>> design/rhfd_taylor_cell.sv
// ---------------------------------------------------------------------------
// rhfd_taylor_cell
// One term of the exp series: term = ((term*r) >> 32) / N, two stages.
// ---------------------------------------------------------------------------
`default_nettype none

module rhfd_taylor_cell #(
  parameter int N = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      prev_valid,
  input  logic [rhfd_pkg::TERM_W-1:0] prev_term,
  input  logic [rhfd_pkg::SUM_W-1:0]  prev_sum,
  input  logic [rhfd_pkg::R_W-1:0]    prev_r,
  input  rhfd_pkg::rhfd_side_t        prev_side,
  output logic                      valid,
  output logic [rhfd_pkg::TERM_W-1:0] term,
  output logic [rhfd_pkg::SUM_W-1:0]  sum,
  output logic [rhfd_pkg::R_W-1:0]    r,
  output rhfd_pkg::rhfd_side_t        side
);
  import rhfd_pkg::*;

  // floor(x/N) for x < 2^32 as (x*M) >> (32+S)
  localparam int          S = $clog2(N);
  localparam logic [32:0] M = 33'(((65'd1 << (32 + S)) + 65'(N) - 65'd1) / 65'(N));

  logic [64:0]       prod_a;
  logic [64:0]       prod_b;
  logic              valid_a;
  logic [R_W-1:0]    hi_a;
  logic [SUM_W-1:0]  sum_a;
  logic [R_W-1:0]    r_a;
  rhfd_side_t        side_a;

  assign prod_a = 65'(prev_term) * 65'(prev_r);
  assign prod_b = 65'(hi_a) * 65'(M);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid   <= 1'b0;
    end else if (en) begin
      valid_a <= prev_valid;
      valid   <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_a   <= prod_a[63:32];
      sum_a  <= prev_sum + SUM_W'(prev_term);
      r_a    <= prev_r;
      side_a <= prev_side;
      term   <= TERM_W'(prod_b >> (32 + S));
      sum    <= sum_a;
      r      <= r_a;
      side   <= side_a;
    end
  end

endmodule

`default_nettype wire

>>> design/relative_humidity_from_dewpoint_unit.sv
// ---------------------------------------------------------------------------
// relative_humidity_from_dewpoint_unit
// Relative humidity from temperature and dewpoint, Magnus/Bolton form.
// ---------------------------------------------------------------------------
// One grid point per transfer: temperature and dewpoint in signed 0.01 degC
// with missing flags; result is 100*exp(a(Td)-a(T)) in 0.01 percent,
// a(x) = 17.67*x/(x+243.5), saturated at 65535, rounded half up. A point is
// missing (humidity 0) if a flag is set or either value is below -240.00
// degC. While in_ready is high the block takes one transfer per clock, and
// it delivers one result per clock while out_ready holds. The row of stages
// is: an input register, 43 restoring-division cells for the two Magnus
// terms (run side by side), one stage forming d, 5 division cells
// splitting d into k*ln2 + r, 16 two-stage Taylor cells for exp(r), a
// multiply-by-10000 stage, a shift/round stage and the output register.
// A one-entry skid lets the row keep taking input while a result waits;
// in_ready drops only when both output register and skid are full.
// ---------------------------------------------------------------------------
`default_nettype none

module relative_humidity_from_dewpoint_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] temperature,
  input  logic signed [15:0] dewpoint,
  input  logic               temperature_missing,
  input  logic               dewpoint_missing,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        humidity,
  output logic               humidity_missing,
  output logic               last_out
);
  import rhfd_pkg::*;

  logic adv;  // whole row steps when the skid is free

  // ---- input stage: numerators and denominators --------------------------
  logic [15:0]          t_abs, d_abs;
  logic [25:0]          t_num, d_num;
  logic signed [16:0]   t_sh, d_sh;
  logic [MAG_DEN_W-1:0] t_den_c, d_den_c;
  logic                 miss_c;

  logic                 p_v;
  logic [MAG_W-1:0]     p_mag_t, p_mag_d;
  logic [MAG_DEN_W-1:0] p_den_t, p_den_d;
  logic                 p_neg_t, p_neg_d, p_miss, p_last;

  assign t_abs   = temperature[15] ? 16'(-temperature) : 16'(temperature);
  assign d_abs   = dewpoint[15] ? 16'(-dewpoint) : 16'(dewpoint);
  assign t_num   = 26'(t_abs) * 26'(MAGNUS_A);
  assign d_num   = 26'(d_abs) * 26'(MAGNUS_A);
  assign t_sh    = 17'(temperature) + DEN_BIAS;
  assign d_sh    = 17'(dewpoint) + DEN_BIAS;
  assign t_den_c = MAG_DEN_W'(t_sh[15:0]) * MAG_DEN_W'(DEN_SCALE);
  assign d_den_c = MAG_DEN_W'(d_sh[15:0]) * MAG_DEN_W'(DEN_SCALE);
  assign miss_c  = temperature_missing | dewpoint_missing |
                   (temperature < MISSING_FLOOR) | (dewpoint < MISSING_FLOOR);

  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (adv) begin
      p_v <= in_valid;
    end
  end

  // den is always even, so den/2 is exact; adding it rounds half away
  always_ff @(posedge clk) begin
    if (adv) begin
      p_mag_t <= {t_num, 32'b0} + MAG_W'(t_den_c[MAG_DEN_W-1:1]);
      p_mag_d <= {d_num, 32'b0} + MAG_W'(d_den_c[MAG_DEN_W-1:1]);
      p_den_t <= t_den_c;
      p_den_d <= d_den_c;
      p_neg_t <= temperature[15];
      p_neg_d <= dewpoint[15];
      p_miss  <= miss_c;
      p_last  <= last_point;
    end
  end

  // ---- Magnus dividers, temperature and dewpoint lanes -------------------
  logic                 mt_v   [0:MAG_Q_W];
  logic [MAG_DEN_W-1:0] mt_rem [0:MAG_Q_W];
  logic [MAG_Q_W-1:0]   mt_low [0:MAG_Q_W];
  logic [MAG_DEN_W-1:0] mt_den [0:MAG_Q_W];
  logic [2:0]           mt_side[0:MAG_Q_W];
  logic                 md_v   [0:MAG_Q_W];
  logic [MAG_DEN_W-1:0] md_rem [0:MAG_Q_W];
  logic [MAG_Q_W-1:0]   md_low [0:MAG_Q_W];
  logic [MAG_DEN_W-1:0] md_den [0:MAG_Q_W];
  logic [0:0]           md_side[0:MAG_Q_W];

  assign mt_v[0]    = p_v;
  assign mt_rem[0]  = MAG_DEN_W'(p_mag_t[MAG_W-1:MAG_Q_W]);
  assign mt_low[0]  = p_mag_t[MAG_Q_W-1:0];
  assign mt_den[0]  = p_den_t;
  assign mt_side[0] = {p_miss, p_last, p_neg_t};
  assign md_v[0]    = p_v;
  assign md_rem[0]  = MAG_DEN_W'(p_mag_d[MAG_W-1:MAG_Q_W]);
  assign md_low[0]  = p_mag_d[MAG_Q_W-1:0];
  assign md_den[0]  = p_den_d;
  assign md_side[0] = p_neg_d;

  for (genvar i = 0; i < MAG_Q_W; i++) begin : g_mag
    rhfd_div_cell #(.DEN_W(MAG_DEN_W), .Q_W(MAG_Q_W), .SIDE_W(3)) u_t (
      .clk(clk), .rst(rst), .en(adv),
      .prev_valid(mt_v[i]), .prev_rem(mt_rem[i]), .prev_low(mt_low[i]),
      .prev_den(mt_den[i]), .prev_side(mt_side[i]),
      .valid(mt_v[i+1]), .rem(mt_rem[i+1]), .low(mt_low[i+1]),
      .den(mt_den[i+1]), .side(mt_side[i+1])
    );
    rhfd_div_cell #(.DEN_W(MAG_DEN_W), .Q_W(MAG_Q_W), .SIDE_W(1)) u_d (
      .clk(clk), .rst(rst), .en(adv),
      .prev_valid(md_v[i]), .prev_rem(md_rem[i]), .prev_low(md_low[i]),
      .prev_den(md_den[i]), .prev_side(md_side[i]),
      .valid(md_v[i+1]), .rem(md_rem[i+1]), .low(md_low[i+1]),
      .den(md_den[i+1]), .side(md_side[i+1])
    );
  end

  // ---- d = a(Td) - a(T), range check, bias by 18*ln2 ----------------------
  logic signed [44:0] a_t, a_d, dq, u_full;
  logic               big_c, small_c;

  logic               g_v;
  logic [U_W-1:0]     g_u;
  logic [3:0]         g_side;

  assign a_t    = mt_side[MAG_Q_W][0] ? -$signed({2'b00, mt_low[MAG_Q_W]})
                                      :  $signed({2'b00, mt_low[MAG_Q_W]});
  assign a_d    = md_side[MAG_Q_W][0] ? -$signed({2'b00, md_low[MAG_Q_W]})
                                      :  $signed({2'b00, md_low[MAG_Q_W]});
  assign dq     = a_d - a_t;
  assign big_c  = dq >= D_HI;
  assign small_c = dq < D_LO;
  assign u_full = dq + K_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= mt_v[MAG_Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_u    <= (big_c | small_c) ? '0 : u_full[U_W-1:0];
      g_side <= {mt_side[MAG_Q_W][2], mt_side[MAG_Q_W][1], big_c, small_c};
    end
  end

  // ---- k = floor(u/ln2) - 18, r = u mod ln2 -------------------------------
  logic                 ln_v   [0:LN2_Q_W];
  logic [LN2_DEN_W-1:0] ln_rem [0:LN2_Q_W];
  logic [LN2_Q_W-1:0]   ln_low [0:LN2_Q_W];
  logic [LN2_DEN_W-1:0] ln_den [0:LN2_Q_W];
  logic [3:0]           ln_side[0:LN2_Q_W];

  assign ln_v[0]    = g_v;
  assign ln_rem[0]  = LN2_DEN_W'(g_u[U_W-1:LN2_Q_W]);
  assign ln_low[0]  = g_u[LN2_Q_W-1:0];
  assign ln_den[0]  = LN2_Q32;
  assign ln_side[0] = g_side;

  for (genvar i = 0; i < LN2_Q_W; i++) begin : g_ln2
    rhfd_div_cell #(.DEN_W(LN2_DEN_W), .Q_W(LN2_Q_W), .SIDE_W(4)) u_c (
      .clk(clk), .rst(rst), .en(adv),
      .prev_valid(ln_v[i]), .prev_rem(ln_rem[i]), .prev_low(ln_low[i]),
      .prev_den(ln_den[i]), .prev_side(ln_side[i]),
      .valid(ln_v[i+1]), .rem(ln_rem[i+1]), .low(ln_low[i+1]),
      .den(ln_den[i+1]), .side(ln_side[i+1])
    );
  end

  // ---- exp(r) series ------------------------------------------------------
  logic              tv   [0:TERMS];
  logic [TERM_W-1:0] tterm[0:TERMS];
  logic [SUM_W-1:0]  tsum [0:TERMS];
  logic [R_W-1:0]    tr   [0:TERMS];
  rhfd_side_t        tside[0:TERMS];

  assign tv[0]    = ln_v[LN2_Q_W];
  assign tterm[0] = ONE_Q32;
  assign tsum[0]  = '0;
  assign tr[0]    = ln_rem[LN2_Q_W];
  assign tside[0] = '{missing: ln_side[LN2_Q_W][3], last: ln_side[LN2_Q_W][2],
                      big: ln_side[LN2_Q_W][1], small_d: ln_side[LN2_Q_W][0],
                      shift: ln_low[LN2_Q_W]};

  for (genvar i = 0; i < TERMS; i++) begin : g_exp
    rhfd_taylor_cell #(.N(i + 1)) u_c (
      .clk(clk), .rst(rst), .en(adv),
      .prev_valid(tv[i]), .prev_term(tterm[i]), .prev_sum(tsum[i]),
      .prev_r(tr[i]), .prev_side(tside[i]),
      .valid(tv[i+1]), .term(tterm[i+1]), .sum(tsum[i+1]),
      .r(tr[i+1]), .side(tside[i+1])
    );
  end

  // ---- scale by 10000 -----------------------------------------------------
  logic [SUM_W-1:0] sum_f;
  logic             s1_v;
  logic [47:0]      s1_val;
  rhfd_side_t       s1_side;

  assign sum_f = tsum[TERMS] + SUM_W'(tterm[TERMS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= tv[TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_val  <= 48'(sum_f) * 48'(HUM_SCALE);
      s1_side <= tside[TERMS];
    end
  end

  // ---- multiply by 2^(k+18), round at bit 50, saturate ---------------------
  logic [67:0] shifted;
  logic [67:0] rounded;
  logic [15:0] hum_c;

  logic        tail_v;
  logic [15:0] tail_hum;
  logic        tail_miss, tail_last;

  assign shifted = 68'(s1_val) << s1_side.shift;
  assign rounded = (shifted + (68'd1 << 49)) >> 50;

  always_comb begin
    if (s1_side.missing || s1_side.small_d) begin
      hum_c = '0;
    end else if (s1_side.big || (rounded[67:16] != '0)) begin
      hum_c = HUM_MAX;
    end else begin
      hum_c = rounded[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail_v <= 1'b0;
    end else if (adv) begin
      tail_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tail_hum  <= hum_c;
      tail_miss <= s1_side.missing;
      tail_last <= s1_side.last;
    end
  end

  // ---- output register with one-entry skid --------------------------------
  logic        s_full;
  logic [15:0] s_hum;
  logic        s_miss, s_last;

  assign adv = ~s_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      s_full    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (s_full) begin
        out_valid <= 1'b1;
        s_full    <= 1'b0;
      end else begin
        out_valid <= tail_v;
      end
    end else if (tail_v) begin
      s_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (s_full) begin
        humidity         <= s_hum;
        humidity_missing <= s_miss;
        last_out         <= s_last;
      end else begin
        humidity         <= tail_hum;
        humidity_missing <= tail_miss;
        last_out         <= tail_last;
      end
    end else if (tail_v && adv) begin
      s_hum  <= tail_hum;
      s_miss <= tail_miss;
      s_last <= tail_last;
    end
  end

  // ---- assertions ---------------------------------------------------------
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    mt_v[MAG_Q_W] == md_v[MAG_Q_W])
    else $error("Magnus divider lanes out of step");

  a_mag_rem: assert property (@(posedge clk) disable iff (rst)
    (mt_v[MAG_Q_W] && !mt_side[MAG_Q_W][2]) |->
      (mt_rem[MAG_Q_W] < mt_den[MAG_Q_W]) && (md_rem[MAG_Q_W] < md_den[MAG_Q_W]))
    else $error("Magnus divider remainder not below divisor");

  a_ln2_rem: assert property (@(posedge clk) disable iff (rst)
    (ln_v[LN2_Q_W] && (ln_side[LN2_Q_W][3:0] == 4'b0000 || ln_side[LN2_Q_W][3:0] == 4'b0100))
      |-> ln_rem[LN2_Q_W] < ln_den[LN2_Q_W])
    else $error("ln2 split remainder out of range");

  a_series_r: assert property (@(posedge clk) disable iff (rst)
    (tv[TERMS] && !tside[TERMS].missing && !tside[TERMS].big && !tside[TERMS].small_d)
      |-> tr[TERMS] < LN2_Q32)
    else $error("series argument corrupted along the row");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_full |-> out_valid)
    else $error("skid holds a result while the output register is empty");

endmodule

`default_nettype wire
